// File: sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and defaults for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Field widths fixed by the interface
  localparam int OFS_W    = 23;
  localparam int ADDR_W   = 32;
  localparam int RANK_W   = 11;   // holds a free count up to 1024 entries
  localparam int CFG_IX_W = 8;
  localparam int CFG_D_W  = 32;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_BLOCKS  = 64;
  localparam int DEF_ALIGN_BYTES = 8;
  localparam int DEF_MAX_REGION  = 4194304;

  // Register indexes
  localparam logic [CFG_IX_W-1:0] REG_BASE = 8'd0;
  localparam logic [CFG_IX_W-1:0] REG_SIZE = 8'd1;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NO_SPACE  = 3'd1,
    STAT_TABLE_FUL = 3'd2,
    STAT_UNMAPPED  = 3'd3,
    STAT_NOT_ALLOC = 3'd4
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_SCAN,
    ST_A_DEC,
    ST_A_UPD,
    ST_F_SCAN,
    ST_F_DEC,
    ST_F_NBR,
    ST_F_MRG,
    ST_F_UPD,
    ST_OUT
  } st_t;

  // One block table entry, as held by a cell
  typedef struct packed {
    logic              used;
    logic              free;
    logic              async;
    logic [RANK_W-1:0] rank;
    logic [OFS_W-1:0]  start;
    logic [OFS_W-1:0]  size;
  } entry_t;

  // Control from the sequencer to every cell
  typedef struct packed {
    logic             shift;
    logic             init;
    logic [OFS_W-1:0] init_size;
  } cell_ctl_t;

endpackage

// File: sv/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One block table entry in the rotating chain; takes its neighbour's entry
// on every shift and reloads the empty table on init.
// ----------------------------------------------------------------------------
module ffba_cell import ffba_pkg::*; #(
  parameter bit HEAD = 1'b0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    d,
  output entry_t    q
);

  entry_t ent_r;
  entry_t init_val;
  entry_t rst_val;

  // Empty table: the head entry is one free block covering the region
  always_comb begin
    init_val       = '0;
    init_val.used  = HEAD;
    init_val.free  = HEAD;
    init_val.size  = HEAD ? ctl.init_size : '0;
  end

  // Reset: the empty table over an unmapped region
  always_comb begin
    rst_val      = init_val;
    rst_val.size = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= rst_val;
    end else if (ctl.init) begin
      ent_r <= init_val;
    end else if (ctl.shift) begin
      ent_r <= d;
    end
  end

  assign q = ent_r;

endmodule

// File: sv/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: watches the entry at the head of the chain, rewrites it as it
// passes, and keeps the request, scan results and output beat.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; #(
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
  parameter int MAX_REGION  = DEF_MAX_REGION
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [79:0]         in_tdata,
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [63:0]         out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0]  cfg_data,
  input  entry_t              head,
  output entry_t              wb,
  output cell_ctl_t           ctl
);

  localparam int CW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [CW-1:0]     CNT_LAST = CW'(MAX_BLOCKS - 1);
  localparam logic [OFS_W:0]    AL_M1    = (OFS_W+1)'(ALIGN_BYTES - 1);
  localparam logic [OFS_W+1:0]  AL_MIN   = (OFS_W+2)'(ALIGN_BYTES);
  localparam logic [OFS_W-1:0]  REG_MAX  = OFS_W'(MAX_REGION);

  st_t state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  logic          last;

  logic [ADDR_W-1:0] base_r;
  logic [OFS_W-1:0]  rsize_r;
  logic [RANK_W-1:0] fc_r;

  logic [OFS_W+1:0]  req_r;
  logic              async_r;
  logic [ADDR_W-1:0] addr_r;

  // allocate scan results
  logic              found_r;
  logic [RANK_W-1:0] brank_r;
  logic [OFS_W-1:0]  bstart_r, bsize_r;
  logic              spare_r, spare_done_r;

  // free scan results
  logic [OFS_W-1:0]  fstart_r, fsize_r;
  logic              fasync_r;
  logic [OFS_W:0]    fend_r;
  logic              nfree_r, pfree_r;
  logic [OFS_W-1:0]  nsize_r, pstart_r, psize_r;
  logic [RANK_W-1:0] nrank_r, prank_r;
  logic [OFS_W-1:0]  mstart_r, msize_r;
  logic [RANK_W-1:0] mrank_r;

  // result beat
  stat_t             rstat_r;
  logic [ADDR_W-1:0] raddr_r;
  logic [OFS_W-1:0]  rsz_r;
  logic              rwas_r;
  logic              out_valid_r;
  logic [63:0]       out_data_r;

  logic in_acc, cfg_acc, out_load;
  logic [OFS_W:0]   al_d, al_o;
  logic [OFS_W+1:0] req_sum, req_val;
  logic             split;
  logic             h_pick, h_fit, h_match, h_next, h_prev, h_blk;
  logic [OFS_W:0]   h_end;
  logic [RANK_W-1:0] dec_n, dec_p;

  assign last     = (cnt_r == CNT_LAST);
  assign in_acc   = in_tvalid && in_tready;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Round both sizes up to the alignment and add, at least one unit
  assign al_d    = ({1'b0, in_tdata[22:0]}  + AL_M1) & ~AL_M1;
  assign al_o    = ({1'b0, in_tdata[45:23]} + AL_M1) & ~AL_M1;
  assign req_sum = {1'b0, al_d} + {1'b0, al_o};
  assign req_val = (req_sum < AL_MIN) ? AL_MIN : req_sum;

  // Head entry tests
  assign split   = (bsize_r != req_r[OFS_W-1:0]);
  assign h_fit   = head.used && head.free && ({2'b0, head.size} >= req_r);
  assign h_pick  = head.used && head.free && (head.rank == brank_r);
  assign h_match = head.used && !head.free &&
                   ((base_r + ADDR_W'(head.start)) == addr_r);
  assign h_end   = {1'b0, head.start} + {1'b0, head.size};
  assign h_next  = head.used && ({1'b0, head.start} == fend_r);
  assign h_prev  = head.used && (h_end == {1'b0, fstart_r});
  assign h_blk   = head.used && !head.free && (head.start == fstart_r);
  assign dec_n   = RANK_W'(nfree_r && (head.rank > nrank_r));
  assign dec_p   = RANK_W'(pfree_r && (head.rank > prank_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (rsize_r == '0) state_nxt = ST_OUT;
          else if (in_tuser == OP_FREE) state_nxt = ST_F_SCAN;
          else state_nxt = ST_A_SCAN;
        end
      end
      ST_A_SCAN: if (last) state_nxt = ST_A_DEC;
      ST_A_DEC: begin
        if (!found_r || (split && !spare_r)) state_nxt = ST_OUT;
        else state_nxt = ST_A_UPD;
      end
      ST_A_UPD:  if (last) state_nxt = ST_OUT;
      ST_F_SCAN: if (last) state_nxt = ST_F_DEC;
      ST_F_DEC:  state_nxt = found_r ? ST_F_NBR : ST_OUT;
      ST_F_NBR:  if (last) state_nxt = ST_F_MRG;
      ST_F_MRG:  state_nxt = ST_F_UPD;
      ST_F_UPD:  if (last) state_nxt = ST_OUT;
      ST_OUT:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: handshakes, chain control and write-back of the head entry
  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    cfg_ready     = (state_r == ST_IDLE);
    ctl.init      = cfg_acc && (cfg_index == REG_SIZE);
    ctl.init_size = (cfg_data[OFS_W-1:0] > REG_MAX) ? REG_MAX : cfg_data[OFS_W-1:0];
    ctl.shift     = (state_r == ST_A_SCAN) || (state_r == ST_A_UPD) ||
                    (state_r == ST_F_SCAN) || (state_r == ST_F_NBR) ||
                    (state_r == ST_F_UPD);
    wb = head;
    unique case (state_r)
      ST_A_UPD: begin
        priority if (h_pick) begin
          wb.free  = 1'b0;
          wb.async = async_r;
          wb.size  = req_r[OFS_W-1:0];
          wb.rank  = '0;
        end else if (!head.used && split && !spare_done_r) begin
          wb.used  = 1'b1;
          wb.free  = 1'b1;
          wb.async = 1'b0;
          wb.start = bstart_r + req_r[OFS_W-1:0];
          wb.size  = bsize_r - req_r[OFS_W-1:0];
          wb.rank  = fc_r - RANK_W'(1);
        end else if (head.used && head.free && (head.rank > brank_r)) begin
          wb.rank  = head.rank - RANK_W'(1);
        end else begin
          wb = head;
        end
      end
      ST_F_UPD: begin
        priority if (nfree_r && h_next) begin
          wb = '0;
        end else if (h_blk) begin
          if (pfree_r) begin
            wb = '0;
          end else begin
            wb.free  = 1'b1;
            wb.async = 1'b0;
            wb.size  = msize_r;
            wb.rank  = mrank_r;
          end
        end else if (pfree_r && head.used && head.free && (head.start == pstart_r)) begin
          wb.size = msize_r;
          wb.rank = mrank_r;
        end else if (head.used && head.free) begin
          wb.rank = head.rank - dec_n - dec_p;
        end else begin
          wb = head;
        end
      end
      default: wb = head;
    endcase
  end

  // State, pass counter and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      base_r  <= '0;
      rsize_r <= '0;
      fc_r    <= RANK_W'(1);
    end else begin
      state_r <= state_nxt;
      if (ctl.shift) cnt_r <= last ? '0 : cnt_r + CW'(1);
      if (cfg_acc && (cfg_index == REG_BASE)) base_r <= cfg_data;
      if (ctl.init) begin
        rsize_r <= ctl.init_size;
        fc_r    <= RANK_W'(1);
      end
      if ((state_r == ST_A_UPD) && last && !split) fc_r <= fc_r - RANK_W'(1);
      if ((state_r == ST_F_UPD) && last) fc_r <= mrank_r + RANK_W'(1);
    end
  end

  // Request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_r    <= req_val;
          async_r  <= in_tdata[46];
          addr_r   <= in_tdata[78:47];
          found_r  <= 1'b0;
          spare_r  <= 1'b0;
          rstat_r  <= STAT_UNMAPPED;
          raddr_r  <= '0;
          rsz_r    <= '0;
          rwas_r   <= 1'b0;
        end
      end
      ST_A_SCAN: begin
        if (!head.used) spare_r <= 1'b1;
        if (h_fit && (!found_r || (head.rank < brank_r))) begin
          found_r  <= 1'b1;
          brank_r  <= head.rank;
          bstart_r <= head.start;
          bsize_r  <= head.size;
        end
      end
      ST_A_DEC: begin
        spare_done_r <= 1'b0;
        rstat_r <= !found_r ? STAT_NO_SPACE : STAT_TABLE_FUL;
      end
      ST_A_UPD: begin
        if (!head.used && split) spare_done_r <= 1'b1;
        if (last) begin
          rstat_r <= STAT_OK;
          raddr_r <= base_r + ADDR_W'(bstart_r);
          rsz_r   <= req_r[OFS_W-1:0];
        end
      end
      ST_F_SCAN: begin
        if (h_match) begin
          found_r  <= 1'b1;
          fstart_r <= head.start;
          fsize_r  <= head.size;
          fasync_r <= head.async;
        end
      end
      ST_F_DEC: begin
        fend_r  <= {1'b0, fstart_r} + {1'b0, fsize_r};
        nfree_r <= 1'b0;
        pfree_r <= 1'b0;
        rstat_r <= STAT_NOT_ALLOC;
      end
      ST_F_NBR: begin
        if (h_next) begin
          nfree_r <= head.free;
          nsize_r <= head.size;
          nrank_r <= head.rank;
        end
        if (h_prev) begin
          pfree_r  <= head.free;
          pstart_r <= head.start;
          psize_r  <= head.size;
          prank_r  <= head.rank;
        end
      end
      ST_F_MRG: begin
        mstart_r <= pfree_r ? pstart_r : fstart_r;
        msize_r  <= (pfree_r ? psize_r : '0) + fsize_r + (nfree_r ? nsize_r : '0);
        mrank_r  <= fc_r - RANK_W'(nfree_r) - RANK_W'(pfree_r);
      end
      ST_F_UPD: begin
        if (last) begin
          rstat_r <= STAT_OK;
          raddr_r <= base_r + ADDR_W'(mstart_r);
          rsz_r   <= msize_r;
          rwas_r  <= fasync_r;
        end
      end
      default: ;
    endcase
  end

  // Output beat: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= {5'b0, rwas_r, rsz_r, raddr_r, rstat_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= RANK_W'(MAX_BLOCKS))
    else $error("free count beyond table depth");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> cnt_r == '0)
    else $error("pass counter not parked while idle");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result beat lost");

  a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[2:0] == STAT_OK)) |-> (out_data_r[57:35] != '0))
    else $error("granted or merged block of zero size");

endmodule

// File: sv/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit block allocator with neighbour coalescing over a block table.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ stream: in_tuser selects allocate or free, and
// in_tdata carries the sizes, async flag and block address. One result beat
// per request leaves on the out_ stream with status, address, size and flag.
// The cfg_ channel writes region_base (index 0) and region_size (index 1);
// writing region_size rebuilds the table as one free block.
// The table lives in a ring of MAX_BLOCKS cells that rotates one entry past
// the sequencer per cycle while a pass runs, so each pass brings every entry
// past the sequencer once. Allocate takes two passes, free three; a request
// that fails its first pass answers after that pass, and a request on an
// unmapped region answers without a pass. One request is in work at a time;
// the next is accepted once the result has been loaded.
// After reset the region is unmapped and every request answers unmapped.
// The result sits in an output register; while the receiver stalls the
// block accepts one further request and holds its result until the
// register drains.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top import ffba_pkg::*; #(
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
  parameter int MAX_REGION  = DEF_MAX_REGION
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // data_bytes[22:0], offset_bytes[45:23], async_flag[46], block_address[78:47]
  input  logic [79:0]         in_tdata,
  // op[0]
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // status[2:0], result_address[34:3], result_size[57:35], was_async[58]
  output logic [63:0]         out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0]  cfg_data
);

  entry_t    q [MAX_BLOCKS];
  entry_t    wb;
  cell_ctl_t ctl;

  // Ring of cells: each takes its upper neighbour, the last takes write-back
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    entry_t d_k;
    if (k == MAX_BLOCKS - 1) begin : g_tail
      assign d_k = wb;
    end else begin : g_mid
      assign d_k = q[k+1];
    end
    ffba_cell #(.HEAD(k == 0)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .d     (d_k),
      .q     (q[k])
    );
  end

  ffba_ctrl #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .ALIGN_BYTES (ALIGN_BYTES),
    .MAX_REGION  (MAX_REGION)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (q[0]),
    .wb         (wb),
    .ctl        (ctl)
  );

endmodule
